// ===== hdl/sss_pkg.sv =====
`default_nettype none

package sss_pkg;

   // default number of scanned digit positions
   localparam int DIGITS_DEFAULT = 4;

   // field widths
   localparam int CODE_W   = 8;
   localparam int INDEX_W  = 2;
   localparam int ENABLE_W = 4;
   localparam int HALF_W   = 10;
   localparam int DWELL_W  = 16;
   localparam int TIMER_W  = 16;
   localparam int COUNT_W  = 4;

   // bits shifted out for each digit
   localparam int BITS_PER_DIGIT = 8;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_RAW_MODE  = 2'd0;
   localparam logic [1:0] REG_BIT_HALF  = 2'd1;
   localparam logic [1:0] REG_DWELL     = 2'd2;

   localparam logic [HALF_W-1:0]  BIT_HALF_RESET = 10'd10;
   localparam logic [DWELL_W-1:0] DWELL_RESET    = 16'd1000;

   // input beat kinds
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // output enable of the shift register is held asserted (low)
   localparam logic OUT_ENABLE_N_LEVEL = 1'b0;

   typedef struct packed {
      logic               raw_mode;
      logic [HALF_W-1:0]  bit_half_ticks;
      logic [DWELL_W-1:0] dwell_ticks;
   } cfg_type;

   typedef struct packed {
      logic                ser_data;
      logic                shift_clk;
      logic                store_clk;
      logic                out_enable_n;
      logic [ENABLE_W-1:0] digit_enable;
      logic                frame_done;
   } pins_type;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_LOW   = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_DWELL = 4'b1000
   } phase_type;

   // common-cathode font, segment order dp g f e d c b a
   function automatic logic [CODE_W-1:0] font_cathode(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] seg;
      case (c)
         8'h00, 8'h30, 8'h4F: seg = 8'h3f;
         8'h01, 8'h31:        seg = 8'h06;
         8'h02, 8'h32:        seg = 8'h5b;
         8'h03, 8'h33:        seg = 8'h4f;
         8'h04, 8'h34:        seg = 8'h66;
         8'h05, 8'h35, 8'h53: seg = 8'h6d;
         8'h06, 8'h36, 8'h47: seg = 8'h7d;
         8'h07, 8'h37:        seg = 8'h07;
         8'h08, 8'h38:        seg = 8'h7f;
         8'h09, 8'h39, 8'h67: seg = 8'h6f;
         8'h2D:               seg = 8'h40;
         8'h2E:               seg = 8'h80;
         8'h3D:               seg = 8'h48;
         8'h0A, 8'h41:        seg = 8'h77;
         8'h0C, 8'h43:        seg = 8'h39;
         8'h0E, 8'h45:        seg = 8'h79;
         8'h0F, 8'h46:        seg = 8'h71;
         8'h48:               seg = 8'h76;
         8'h4A:               seg = 8'h1e;
         8'h4C:               seg = 8'h38;
         8'h4E:               seg = 8'h37;
         8'h50, 8'h70:        seg = 8'h73;
         8'h55:               seg = 8'h3e;
         8'h5F:               seg = 8'h08;
         8'h0B, 8'h62:        seg = 8'h7c;
         8'h63:               seg = 8'h58;
         8'h0D, 8'h64:        seg = 8'h5e;
         8'h65:               seg = 8'h7b;
         8'h68:               seg = 8'h74;
         8'h69:               seg = 8'h10;
         8'h6E:               seg = 8'h54;
         8'h6F:               seg = 8'h5c;
         8'h71:               seg = 8'h67;
         8'h72:               seg = 8'h50;
         8'h74:               seg = 8'h78;
         8'h75:               seg = 8'h1c;
         8'h79:               seg = 8'h6e;
         default:             seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sss_req_if.sv =====
`default_nettype none

interface sss_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [1:0] digit_index;
   logic [7:0] digit_code;

   modport source (output valid, action, digit_index, digit_code, input ready);
   modport sink   (input valid, action, digit_index, digit_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/sss_rsp_if.sv =====
`default_nettype none

interface sss_rsp_if;
   logic       valid;
   logic       ready;
   logic       ser_data;
   logic       shift_clk;
   logic       store_clk;
   logic       out_enable_n;
   logic [3:0] digit_enable;
   logic       frame_done;

   modport source (output valid, ser_data, shift_clk, store_clk, out_enable_n,
                   digit_enable, frame_done, input ready);
   modport sink   (input valid, ser_data, shift_clk, store_clk, out_enable_n,
                   digit_enable, frame_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/sss_csr.sv =====
`default_nettype none

module sss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output sss_pkg::cfg_type                 cfg
);
   import sss_pkg::*;

   logic               raw_mode_ff, raw_mode_in;
   logic [HALF_W-1:0]  bit_half_ff, bit_half_in;
   logic [DWELL_W-1:0] dwell_ff, dwell_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // register write decode
   always_comb begin
      raw_mode_in = raw_mode_ff;
      bit_half_in = bit_half_ff;
      dwell_in    = dwell_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RAW_MODE: raw_mode_in = pwdata[0];
            REG_BIT_HALF: bit_half_in = pwdata[HALF_W-1:0];
            REG_DWELL:    dwell_in    = pwdata[DWELL_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         bit_half_ff <= BIT_HALF_RESET;
         dwell_ff    <= DWELL_RESET;
      end else begin
         raw_mode_ff <= raw_mode_in;
         bit_half_ff <= bit_half_in;
         dwell_ff    <= dwell_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_RAW_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, raw_mode_ff};
         REG_BIT_HALF: prdata = {{(CSR_DATA_W-HALF_W){1'b0}}, bit_half_ff};
         REG_DWELL:    prdata = {{(CSR_DATA_W-DWELL_W){1'b0}}, dwell_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.raw_mode       = raw_mode_ff;
   assign cfg.bit_half_ticks = bit_half_ff;
   assign cfg.dwell_ticks    = dwell_ff;

endmodule

`default_nettype wire

// ===== hdl/sss_scan.sv =====
`default_nettype none

module sss_scan #(
   parameter int DIGITS = sss_pkg::DIGITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           beat_en,
   input  logic                           action,
   input  logic [sss_pkg::INDEX_W-1:0]    digit_index,
   input  logic [sss_pkg::CODE_W-1:0]     digit_code,
   input  sss_pkg::cfg_type               cfg,
   output sss_pkg::pins_type              pins
);
   import sss_pkg::*;

   localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [CODE_W-1:0]  store_ff [DIGITS];
   logic               store_we;
   logic [DIG_W-1:0]   store_idx;

   logic [DIG_W-1:0]   digit_ff, digit_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [CODE_W-1:0]  byte_ff, byte_in;
   pins_type           pins_ff, pins_in;

   logic [CODE_W-1:0]  code_sel;
   logic [CODE_W-1:0]  shifted;
   logic [COUNT_W-1:0] count_inc;
   logic [ENABLE_W-1:0] digit_onehot;
   logic               half_done;
   logic               dwell_done;

   // digit code writes
   assign store_we  = beat_en && (action == ACT_WRITE) && (32'(digit_index) < DIGITS);
   assign store_idx = DIG_W'(digit_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_we) begin
         store_ff[store_idx] <= digit_code;
      end
   end

   // datapath helpers
   assign code_sel   = cfg.raw_mode ? store_ff[digit_ff] : font_cathode(store_ff[digit_ff]);
   assign shifted    = {byte_ff[CODE_W-2:0], 1'b0};
   assign count_inc  = count_ff + COUNT_W'(1);
   assign half_done  = timer_ff >= {{(TIMER_W-HALF_W){1'b0}}, cfg.bit_half_ticks};
   assign dwell_done = timer_ff >= cfg.dwell_ticks;

   always_comb begin
      for (int i = 0; i < ENABLE_W; i++) begin
         digit_onehot[i] = (32'(digit_ff) == i);
      end
   end

   // scan sequencer, one step per tick beat
   always_comb begin
      digit_in = digit_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      byte_in  = byte_ff;
      pins_in  = pins_ff;
      if (beat_en) begin
         pins_in.frame_done = 1'b0;
         if (action == ACT_TICK) begin
            case (phase_ff)
               PH_START: begin
                  byte_in           = code_sel;
                  count_in          = '0;
                  pins_in           = '0;
                  pins_in.ser_data  = code_sel[CODE_W-1];
                  pins_in.out_enable_n = OUT_ENABLE_N_LEVEL;
                  timer_in          = TIMER_W'(1);
                  phase_in          = PH_LOW;
               end
               PH_LOW: begin
                  if (half_done) begin
                     pins_in.shift_clk = 1'b1;
                     timer_in          = TIMER_W'(1);
                     phase_in          = PH_HIGH;
                  end else begin
                     timer_in = timer_ff + TIMER_W'(1);
                  end
               end
               PH_HIGH: begin
                  if (half_done) begin
                     byte_in  = shifted;
                     count_in = count_inc;
                     timer_in = TIMER_W'(1);
                     if (count_inc >= COUNT_W'(BITS_PER_DIGIT)) begin
                        // last bit clocked in: latch and light the digit
                        pins_in.store_clk    = 1'b1;
                        pins_in.digit_enable = digit_onehot;
                        phase_in             = PH_DWELL;
                     end else begin
                        pins_in              = '0;
                        pins_in.ser_data     = shifted[CODE_W-1];
                        pins_in.out_enable_n = OUT_ENABLE_N_LEVEL;
                        phase_in             = PH_LOW;
                     end
                  end else begin
                     timer_in = timer_ff + TIMER_W'(1);
                  end
               end
               PH_DWELL: begin
                  if (dwell_done) begin
                     pins_in.digit_enable = '0;
                     if (digit_ff == DIG_W'(DIGITS - 1)) begin
                        pins_in.frame_done = 1'b1;
                        digit_in           = '0;
                     end else begin
                        digit_in = digit_ff + DIG_W'(1);
                     end
                     timer_in = '0;
                     phase_in = PH_START;
                  end else begin
                     timer_in = timer_ff + TIMER_W'(1);
                  end
               end
               default: begin
                  phase_in = PH_START;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         count_ff <= '0;
         phase_ff <= PH_START;
         timer_ff <= '0;
         byte_ff  <= '0;
         pins_ff  <= '0;
      end else begin
         digit_ff <= digit_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         byte_ff  <= byte_in;
         pins_ff  <= pins_in;
      end
   end

   assign pins = pins_ff;

endmodule

`default_nettype wire

// ===== hdl/seven_segment_scan_serializer_core.sv =====
// Seven-segment scan serializer core.
//
// Input channel (req_bus): each beat is either a digit write (action 0:
// digit_code stored at digit_index) or one time tick (action 1) that
// advances the serial shift, latch and digit-enable timing by one step.
// Result channel (rsp_bus): exactly one beat per input beat, carrying the
// pin levels after that step and frame_done for the tick that ends the
// last digit's dwell. A write beat repeats the pins but clears frame_done.
// Configuration (APB): raw_mode at 0x0, bit_half_ticks at 0x4,
// dwell_ticks at 0x8; a write lands on the access cycle, pready is tied high.
//
// The pins register that closes the single combinational step is the result
// register. Throughput is one beat per cycle while rsp_bus.ready is high;
// the tick sequencer and store update complete in that one step. Reset
// clears the digit codes, the sequencer and all pins and loads the register
// defaults. While a result is waiting and rsp_bus.ready is low, req_bus.ready
// drops and the result holds until it is taken.
`default_nettype none

module seven_segment_scan_serializer_core #(
   parameter int DIGITS = sss_pkg::DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   sss_req_if.sink                          req_bus,
   sss_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import sss_pkg::*;

   cfg_type  cfg;
   pins_type pins;
   logic     req_beat;
   logic     rsp_valid_ff, rsp_valid_in;

   sss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // take a new beat whenever the result slot is free or being emptied
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat      = req_bus.valid && req_bus.ready;

   sss_scan #(
      .DIGITS (DIGITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .beat_en     (req_beat),
      .action      (req_bus.action),
      .digit_index (req_bus.digit_index),
      .digit_code  (req_bus.digit_code),
      .cfg         (cfg),
      .pins        (pins)
   );

   // result valid
   always_comb begin
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ser_data     = pins.ser_data;
   assign rsp_bus.shift_clk    = pins.shift_clk;
   assign rsp_bus.store_clk    = pins.store_clk;
   assign rsp_bus.out_enable_n = pins.out_enable_n;
   assign rsp_bus.digit_enable = pins.digit_enable;
   assign rsp_bus.frame_done   = pins.frame_done;

endmodule

`default_nettype wire

// ===== tb/sv/seven_segment_scan_serializer_core_test.sv =====
`timescale 1ns / 100ps

module seven_segment_scan_serializer_core_test;
   import sss_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int SETTLE_TICKS = 3;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   sss_req_if req_bus ();
   sss_rsp_if rsp_bus ();

   seven_segment_scan_serializer_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // scan predictor state
   logic [CODE_W-1:0]  code_store [DIGITS_DEFAULT];
   logic [1:0]         scan_pos;
   logic [COUNT_W-1:0] bits_sent;
   phase_type          scan_step;
   logic [TIMER_W-1:0] step_count;
   logic [CODE_W-1:0]  out_byte;
   pins_type           pin_now;
   logic               cfg_raw;
   logic [HALF_W-1:0]  cfg_half;
   logic [DWELL_W-1:0] cfg_dwell;

   pins_type pins_due [$];
   pins_type pins_got;
   pins_type pins_want;

   int send_idle_pct;
   int stall_pct;
   int fail_count;
   int beats_sent;
   int beats_seen;
   int frames_seen;
   int csr_writes;
   int quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // common-cathode glyphs, segment order dp g f e d c b a
   function automatic logic [CODE_W-1:0] glyph_segments(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] seg;
      seg = 8'h00;
      if (c <= 8'h09 || (c >= 8'h30 && c <= 8'h39)) begin
         case (c[3:0])
            4'd0: seg = 8'h3f;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5b;
            4'd3: seg = 8'h4f;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6d;
            4'd6: seg = 8'h7d;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7f;
            default: seg = 8'h6f;
         endcase
      end else begin
         case (c)
            8'h2D: seg = 8'h40;
            8'h2E: seg = 8'h80;
            8'h3D: seg = 8'h48;
            8'h0A, 8'h41: seg = 8'h77;
            8'h0C, 8'h43: seg = 8'h39;
            8'h0E, 8'h45: seg = 8'h79;
            8'h0F, 8'h46: seg = 8'h71;
            8'h47: seg = 8'h7d;
            8'h48: seg = 8'h76;
            8'h4A: seg = 8'h1e;
            8'h4C: seg = 8'h38;
            8'h4E: seg = 8'h37;
            8'h4F: seg = 8'h3f;
            8'h50: seg = 8'h73;
            8'h53: seg = 8'h6d;
            8'h55: seg = 8'h3e;
            8'h5F: seg = 8'h08;
            8'h0B, 8'h62: seg = 8'h7c;
            8'h63: seg = 8'h58;
            8'h0D, 8'h64: seg = 8'h5e;
            8'h65: seg = 8'h7b;
            8'h67: seg = 8'h6f;
            8'h68: seg = 8'h74;
            8'h69: seg = 8'h10;
            8'h6E: seg = 8'h54;
            8'h6F: seg = 8'h5c;
            8'h70: seg = 8'h73;
            8'h71: seg = 8'h67;
            8'h72: seg = 8'h50;
            8'h74: seg = 8'h78;
            8'h75: seg = 8'h1c;
            8'h79: seg = 8'h6e;
            default: seg = 8'h00;
         endcase
      end
      return seg;
   endfunction

   function automatic void clear_scan_model();
      for (int i = 0; i < DIGITS_DEFAULT; i++) code_store[i] = '0;
      scan_pos   = '0;
      bits_sent  = '0;
      scan_step  = PH_START;
      step_count = '0;
      out_byte   = '0;
      pin_now    = '0;
      cfg_raw    = 1'b0;
      cfg_half   = BIT_HALF_RESET;
      cfg_dwell  = DWELL_RESET;
   endfunction

   // advance the scan model by one accepted beat and queue the pins it leaves
   function automatic void predict_pins(input logic act, input logic [1:0] idx,
                                        input logic [CODE_W-1:0] code);
      pins_type pins;
      logic     frame;
      frame = 1'b0;
      if (act == ACT_WRITE) begin
         code_store[idx] = code;
      end else begin
         case (scan_step)
            PH_START: begin
               out_byte = cfg_raw ? code_store[scan_pos] : glyph_segments(code_store[scan_pos]);
               bits_sent = '0;
               pin_now = '0;
               pin_now.ser_data = out_byte[7];
               step_count = TIMER_W'(1);
               scan_step = PH_LOW;
            end
            PH_LOW: begin
               if (step_count >= cfg_half) begin
                  pin_now.shift_clk = 1'b1;
                  step_count = TIMER_W'(1);
                  scan_step = PH_HIGH;
               end else begin
                  step_count++;
               end
            end
            PH_HIGH: begin
               if (step_count >= cfg_half) begin
                  out_byte = out_byte << 1;
                  bits_sent++;
                  if (bits_sent >= BITS_PER_DIGIT) begin
                     // latch and light the digit; data and shift clock hold
                     pin_now.store_clk = 1'b1;
                     pin_now.out_enable_n = OUT_ENABLE_N_LEVEL;
                     pin_now.digit_enable = 4'b0001 << scan_pos;
                     scan_step = PH_DWELL;
                  end else begin
                     pin_now = '0;
                     pin_now.ser_data = out_byte[7];
                     scan_step = PH_LOW;
                  end
                  step_count = TIMER_W'(1);
               end else begin
                  step_count++;
               end
            end
            default: begin
               if (step_count >= cfg_dwell) begin
                  pin_now.digit_enable = '0;
                  if (scan_pos == 2'(DIGITS_DEFAULT - 1)) frame = 1'b1;
                  scan_pos++;
                  step_count = '0;
                  scan_step = PH_START;
               end else begin
                  step_count++;
               end
            end
         endcase
      end
      pins = pin_now;
      pins.frame_done = frame;
      pins_due.push_back(pins);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result beats against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pins_got.ser_data     = rsp_bus.ser_data;
         pins_got.shift_clk    = rsp_bus.shift_clk;
         pins_got.store_clk    = rsp_bus.store_clk;
         pins_got.out_enable_n = rsp_bus.out_enable_n;
         pins_got.digit_enable = rsp_bus.digit_enable;
         pins_got.frame_done   = rsp_bus.frame_done;
         beats_seen++;
         if (pins_got.frame_done) frames_seen++;
         if (pins_due.size() == 0) begin
            $error("result beat with no expectation waiting");
            fail_count++;
         end else begin
            pins_want = pins_due.pop_front();
            check_field("ser_data", int'(pins_want.ser_data), int'(pins_got.ser_data));
            check_field("shift_clk", int'(pins_want.shift_clk), int'(pins_got.shift_clk));
            check_field("store_clk", int'(pins_want.store_clk), int'(pins_got.store_clk));
            check_field("out_enable_n", int'(pins_want.out_enable_n),
                        int'(pins_got.out_enable_n));
            check_field("digit_enable", int'(pins_want.digit_enable),
                        int'(pins_got.digit_enable));
            check_field("frame_done", int'(pins_want.frame_done), int'(pins_got.frame_done));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // one input beat; valid stays high afterwards until the next call or a drain
   task automatic send_beat(input logic act, input logic [1:0] idx,
                            input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.digit_index <= idx;
      req_bus.digit_code  <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_pins(act, idx, code);
      beats_sent++;
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) send_beat(ACT_TICK, 2'($urandom), 8'($urandom));
   endtask

   // codes biased towards font entries, plus plenty of dark ones
   function automatic logic [CODE_W-1:0] pick_code();
      logic [CODE_W-1:0] c;
      case ($urandom_range(4))
         0: c = 8'($urandom_range(8'h0F));
         1: c = 8'($urandom_range(8'h30, 8'h39));
         2: c = 8'($urandom_range(8'h41, 8'h7A));
         3: begin
            case ($urandom_range(3))
               0: c = 8'h2D;
               1: c = 8'h2E;
               2: c = 8'h3D;
               default: c = 8'h5F;
            endcase
         end
         default: c = 8'($urandom);
      endcase
      return c;
   endfunction

   task automatic send_random_beat(input int write_pct);
      if ($urandom_range(99) < write_pct)
         send_beat(ACT_WRITE, 2'($urandom_range(3)), pick_code());
      else
         send_beat(ACT_TICK, 2'($urandom), 8'($urandom));
   endtask

   // hold the sender until every expected result is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pins_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // APB write: setup then access, then idle with psel low
   task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (reg_index)
         REG_RAW_MODE: cfg_raw   = value[0];
         REG_BIT_HALF: cfg_half  = value[HALF_W-1:0];
         REG_DWELL:    cfg_dwell = value[DWELL_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_timing(input logic raw, input int half, input int dwell);
      write_register(REG_RAW_MODE, 32'(raw));
      write_register(REG_BIT_HALF, 32'(half));
      write_register(REG_DWELL, 32'(dwell));
   endtask

   // pins straight after reset with the default timing
   task automatic test_reset_state();
      send_beat(ACT_TICK, 2'd0, 8'h00);
      send_beat(ACT_WRITE, 2'd0, 8'h00);
      send_beat(ACT_TICK, 2'd3, 8'hFF);
   endtask

   // font edges, dark extreme codes and a write landing mid-shift
   task automatic test_digit_codes();
      drain_results();
      set_timing(1'b0, 1, 1);
      send_beat(ACT_WRITE, 2'd0, 8'hFF);
      send_beat(ACT_WRITE, 2'd1, 8'h2E);
      send_beat(ACT_WRITE, 2'd2, 8'h4F);
      send_beat(ACT_WRITE, 2'd3, 8'h79);
      send_ticks(8);
      send_beat(ACT_WRITE, 2'd3, 8'h80);
      send_ticks(9);
   endtask

   // zero half period and zero dwell behave as one tick
   task automatic test_zero_timing();
      drain_results();
      set_timing(1'b0, 0, 0);
      for (int i = 0; i < 150; i++) send_random_beat(15);
   endtask

   // widest timings, then shortened while a phase is in progress
   task automatic test_extreme_timing();
      drain_results();
      set_timing(1'b1, 1023, 65535);
      send_ticks(30);
      drain_results();
      write_register(REG_BIT_HALF, 32'd1);
      send_ticks(25);
      drain_results();
      write_register(REG_DWELL, 32'd1);
      send_ticks(6);
   endtask

   task automatic test_random_scan(input int sender_pct, input int receiver_pct,
                                   input int beats);
      drain_results();
      set_timing(1'($urandom_range(1)), $urandom_range(1, 3), $urandom_range(1, 8));
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
      for (int i = 0; i < beats; i++) begin
         if (i == beats / 2) drain_results();
         send_random_beat(20);
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_TICK;
      req_bus.digit_index <= '0;
      req_bus.digit_code  <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      beats_sent    = 0;
      csr_writes    = 0;
      clear_scan_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_digit_codes();
      test_zero_timing();
      test_extreme_timing();
      test_random_scan(0, 0, 300);
      test_random_scan(59, 0, 300);
      test_random_scan(0, 59, 300);
      test_random_scan(31, 31, 300);

      drain_results();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (5) @(posedge clock);
      $display("Sent %0d input beats, checked %0d result beats, %0d frames completed.",
               beats_sent, beats_seen, frames_seen);
      $display("Made %0d register writes across raw/font modes and zero to maximum timings.",
               csr_writes);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sss_pkg.sv
hdl/sss_req_if.sv
hdl/sss_rsp_if.sv
hdl/sss_csr.sv
hdl/sss_scan.sv
hdl/seven_segment_scan_serializer_core.sv
tb/sv/seven_segment_scan_serializer_core_test.sv
